@@ rtl/triangle_scanline_edge_interpolator_top_defines.svh @@
// Assertion macros used by the edge interpolator top level.
`ifndef TRIANGLE_SCANLINE_EDGE_INTERPOLATOR_TOP_DEFINES_SVH
`define TRIANGLE_SCANLINE_EDGE_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TESI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TESI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tesi_pkg.sv @@
// Types, constants and the divider step shared by the edge interpolator.
`default_nettype none
package tesi_pkg;

  localparam int COORD_W        = 16;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int LANES_PER_EDGE = 4;
  localparam int EDGES          = 2;
  localparam int LANES          = LANES_PER_EDGE * EDGES;
  localparam int DIV_STEPS      = 2;
  localparam int DIV_STAGES     = COORD_W / DIV_STEPS;

  // Lane order inside one edge
  localparam int LANE_X = 0;
  localparam int LANE_D = 1;
  localparam int LANE_U = 2;
  localparam int LANE_V = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_VERTEX_A = 2'd0;
  localparam logic [1:0] REG_VERTEX_B = 2'd1;
  localparam logic [1:0] REG_VERTEX_C = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  // Packed exactly as the register layout: x, y, depth, u, v
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] d;
    logic [7:0]  u;
    logic [7:0]  v;
  } vertex_t;

  // Side data that rides along with the division
  typedef struct packed {
    logic                   span;
    coord_t [EDGES-1:0]     dy;
    logic   [LANES-1:0]     neg;
    coord_t [LANES-1:0]     start;
  } side_t;

  // One lane of the restoring divider: partial remainder and quotient/dividend shifter
  typedef struct packed {
    coord_t rem;
    coord_t acc;
  } div_lane_t;

  // One restoring division step; remainder stays below dy
  function automatic div_lane_t div_step(div_lane_t l, coord_t dy);
    logic [COORD_W:0] r2;
    logic             qbit;
    div_lane_t        res;
    r2   = {l.rem, l.acc[COORD_W-1]};
    qbit = (r2 >= {1'b0, dy});
    if (qbit) begin
      r2 = r2 - {1'b0, dy};
    end
    res.rem = r2[COORD_W-1:0];
    res.acc = {l.acc[COORD_W-2:0], qbit};
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tesi_sort.sv @@
// Vertex registers and the y-order compare-swap network.
`default_nettype none
module tesi_sort
  import tesi_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_wdata,
  output vertex_t [2:0]      vtx_sorted
);

  vertex_t          va_r, vb_r, vc_r;
  vertex_t          va_nxt, vb_nxt, vc_nxt;
  vertex_t [2:0]    sorted_r, sorted_nxt;

  // Register write, then three compare-swaps on the written values:
  // (0,1), (1,2), (0,1); equal y keeps order
  always_comb begin
    vertex_t t;
    vertex_t [2:0] s;
    va_nxt = va_r;
    vb_nxt = vb_r;
    vc_nxt = vc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_A: va_nxt = vertex_t'(cfg_wdata);
        REG_VERTEX_B: vb_nxt = vertex_t'(cfg_wdata);
        REG_VERTEX_C: vc_nxt = vertex_t'(cfg_wdata);
        default: ;
      endcase
    end
    s[0] = va_nxt;
    s[1] = vb_nxt;
    s[2] = vc_nxt;
    if (s[0].y > s[1].y) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    if (s[1].y > s[2].y) begin
      t = s[1]; s[1] = s[2]; s[2] = t;
    end
    if (s[0].y > s[1].y) begin
      t = s[0]; s[0] = s[1]; s[1] = t;
    end
    sorted_nxt = s;
  end

  // Vertex registers and sorted copy, updated at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= '0;
      vb_r     <= '0;
      vc_r     <= '0;
      sorted_r <= '0;
    end else begin
      va_r     <= va_nxt;
      vb_r     <= vb_nxt;
      vc_r     <= vc_nxt;
      sorted_r <= sorted_nxt;
    end
  end

  assign vtx_sorted = sorted_r;

endmodule
`default_nettype wire

@@ rtl/tesi_setup.sv @@
// Edge selection, endpoint differences and offset products (two stages).
`default_nettype none
module tesi_setup
  import tesi_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vertex_t [2:0]               vtx_sorted,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [COORD_W-1:0]          in_line,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output side_t                            out_side,
  output logic [LANES-1:0][PROD_W-1:0]     out_prod
);

  typedef struct packed {
    coord_t [EDGES-1:0] off;
    coord_t [LANES-1:0] mag;
  } setup_t;

  logic                          a_valid_r, b_valid_r;
  logic                          a_en, b_en;
  side_t                         a_side_r, a_side_nxt, b_side_r;
  setup_t                        a_setup_r, a_setup_nxt;
  logic [LANES-1:0][PROD_W-1:0]  b_prod_r, b_prod_nxt;

  assign b_en     = !b_valid_r || out_ready;
  assign a_en     = !a_valid_r || b_en;
  assign in_ready = a_en;

  // Stage A: span test, edge choice, |end - start| per lane
  always_comb begin
    vertex_t p0, p1, p2;
    vertex_t [EDGES-1:0] ea, eb;
    coord_t  [LANES-1:0] sv, ev;
    logic span, upper;
    p0    = vtx_sorted[0];
    p1    = vtx_sorted[1];
    p2    = vtx_sorted[2];
    span  = (p0.y != p2.y) && (in_line >= p0.y) && (in_line <= p2.y);
    upper = (in_line <= p1.y) && (p1.y > p0.y);
    ea[0] = p0;
    eb[0] = p2;
    ea[1] = upper ? p0 : p1;
    eb[1] = upper ? p1 : p2;
    a_side_nxt.span = span;
    for (int e = 0; e < EDGES; e++) begin
      if (span) begin
        a_setup_nxt.off[e] = in_line - ea[e].y;
        a_side_nxt.dy[e]   = eb[e].y - ea[e].y;
      end else begin
        // keep the divider clear of a zero divisor
        a_setup_nxt.off[e] = '0;
        a_side_nxt.dy[e]   = coord_t'(1);
      end
      sv[e*LANES_PER_EDGE + LANE_X] = ea[e].x;
      sv[e*LANES_PER_EDGE + LANE_D] = ea[e].d;
      sv[e*LANES_PER_EDGE + LANE_U] = {8'b0, ea[e].u};
      sv[e*LANES_PER_EDGE + LANE_V] = {8'b0, ea[e].v};
      ev[e*LANES_PER_EDGE + LANE_X] = eb[e].x;
      ev[e*LANES_PER_EDGE + LANE_D] = eb[e].d;
      ev[e*LANES_PER_EDGE + LANE_U] = {8'b0, eb[e].u};
      ev[e*LANES_PER_EDGE + LANE_V] = {8'b0, eb[e].v};
    end
    for (int i = 0; i < LANES; i++) begin
      a_side_nxt.start[i] = sv[i];
      a_side_nxt.neg[i]   = ev[i] < sv[i];
      a_setup_nxt.mag[i]  = (ev[i] < sv[i]) ? (sv[i] - ev[i]) : (ev[i] - sv[i]);
    end
  end

  // Stage B: offset times magnitude
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      b_prod_nxt[i] = {{COORD_W{1'b0}}, a_setup_r.off[i / LANES_PER_EDGE]}
                    * {{COORD_W{1'b0}}, a_setup_r.mag[i]};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_en) a_valid_r <= in_valid;
      if (b_en) b_valid_r <= a_valid_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_side_r  <= a_side_nxt;
      a_setup_r <= a_setup_nxt;
    end
    if (b_en) begin
      b_side_r <= a_side_r;
      b_prod_r <= b_prod_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_side  = b_side_r;
  assign out_prod  = b_prod_r;

endmodule
`default_nettype wire

@@ rtl/tesi_div.sv @@
// Pipelined restoring divider, eight lanes, two quotient bits per stage.
`default_nettype none
module tesi_div
  import tesi_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire side_t                       in_side,
  input  wire logic [LANES-1:0][PROD_W-1:0] in_prod,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output side_t                            out_side,
  output div_lane_t [LANES-1:0]            out_lane
);

  logic [DIV_STAGES-1:0]  v_r;
  logic [DIV_STAGES:0]    en;
  side_t                  side_r [DIV_STAGES];
  div_lane_t [LANES-1:0]  lane_r [DIV_STAGES];
  div_lane_t [LANES-1:0]  init;

  // Quotient fits the low half, so the high half seeds the remainder
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      init[i].rem = in_prod[i][PROD_W-1:COORD_W];
      init[i].acc = in_prod[i][COORD_W-1:0];
    end
  end

  assign en[DIV_STAGES] = out_ready;
  assign in_ready       = en[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_lane_t [LANES-1:0] src, res;
    side_t                 src_side;
    logic                  src_v;

    if (k == 0) begin : g_head
      assign src      = init;
      assign src_side = in_side;
      assign src_v    = in_valid;
    end else begin : g_body
      assign src      = lane_r[k-1];
      assign src_side = side_r[k-1];
      assign src_v    = v_r[k-1];
    end

    assign en[k] = !v_r[k] || en[k+1];

    // Two division steps per lane
    always_comb begin
      div_lane_t t;
      for (int i = 0; i < LANES; i++) begin
        t = src[i];
        for (int s = 0; s < DIV_STEPS; s++) begin
          t = div_step(t, src_side.dy[i / LANES_PER_EDGE]);
        end
        res[i] = t;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= src_side;
        lane_r[k] <= res;
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];
  assign out_lane  = lane_r[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ rtl/triangle_scanline_edge_interpolator_top.sv @@
// Top level of the triangle scanline edge interpolator.
//
//  Port group   Direction  Handshake        Carries
//  cfg_*        in         write enable     vertex registers (index 0..2)
//  in_*         in         valid / ready    one scanline request
//  out_*        out        valid / ready    span flag and left/right edge points
//
// One request enters per cycle while in_ready is high; it passes setup, divider, output.
// The divider pipeline (two quotient bits per stage) sets the depth.
// Reset clears the vertex registers to zero and empties the pipeline.
// A stalled output holds its result; upstream stages keep filling bubbles
// and in_ready drops only when every stage is full.
`default_nettype none
`include "triangle_scanline_edge_interpolator_top_defines.svh"
module triangle_scanline_edge_interpolator_top
  import tesi_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [15:0]  in_scan_line,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_span_valid,
  output logic [15:0]       out_left_x,
  output logic [15:0]       out_left_depth,
  output logic [7:0]        out_left_u,
  output logic [7:0]        out_left_v,
  output logic [15:0]       out_right_x,
  output logic [15:0]       out_right_depth,
  output logic [7:0]        out_right_u,
  output logic [7:0]        out_right_v
);

  vertex_t [2:0]                  vtx_sorted;
  logic                           su_valid, su_ready;
  side_t                          su_side;
  logic [LANES-1:0][PROD_W-1:0]   su_prod;
  logic                           dv_valid, dv_ready;
  side_t                          dv_side;
  div_lane_t [LANES-1:0]          dv_lane;

  logic                           out_valid_r, out_en;
  logic                           span_r, span_nxt;
  coord_t [LANES_PER_EDGE-1:0]    left_r, left_nxt, right_r, right_nxt;

  tesi_sort u_sort (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .vtx_sorted (vtx_sorted)
  );

  tesi_setup u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .vtx_sorted (vtx_sorted),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_line    (in_scan_line),
    .out_valid  (su_valid),
    .out_ready  (su_ready),
    .out_side   (su_side),
    .out_prod   (su_prod)
  );

  tesi_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (su_valid),
    .in_ready   (su_ready),
    .in_side    (su_side),
    .in_prod    (su_prod),
    .out_valid  (dv_valid),
    .out_ready  (dv_ready),
    .out_side   (dv_side),
    .out_lane   (dv_lane)
  );

  assign out_en   = !out_valid_r || out_ready;
  assign dv_ready = out_en;

  // Floor correction, start offset, then order points by x (zero points for an empty span)
  always_comb begin
    coord_t [LANES-1:0] val;
    coord_t [LANES_PER_EDGE-1:0] lp, rp;
    logic rem_nz;
    for (int i = 0; i < LANES; i++) begin
      rem_nz = (dv_lane[i].rem != '0);
      if (dv_side.neg[i]) begin
        val[i] = dv_side.start[i] - dv_lane[i].acc - {{(COORD_W-1){1'b0}}, rem_nz};
      end else begin
        val[i] = dv_side.start[i] + dv_lane[i].acc;
      end
    end
    for (int j = 0; j < LANES_PER_EDGE; j++) begin
      lp[j] = val[j];
      rp[j] = val[LANES_PER_EDGE + j];
    end
    span_nxt = dv_side.span;
    if (!dv_side.span) begin
      left_nxt  = '0;
      right_nxt = '0;
    end else if (lp[LANE_X] > rp[LANE_X]) begin
      left_nxt  = rp;
      right_nxt = lp;
    end else begin
      left_nxt  = lp;
      right_nxt = rp;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      span_r  <= span_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_span_valid  = span_r;
  assign out_left_x      = left_r[LANE_X];
  assign out_left_depth  = left_r[LANE_D];
  assign out_left_u      = left_r[LANE_U][7:0];
  assign out_left_v      = left_r[LANE_V][7:0];
  assign out_right_x     = right_r[LANE_X];
  assign out_right_depth = right_r[LANE_D];
  assign out_right_u     = right_r[LANE_U][7:0];
  assign out_right_v     = right_r[LANE_V][7:0];

  // Checks
  `TESI_ASSERT_IMP(a_empty_zero, out_valid && !out_span_valid, (out_left_x == 16'd0) && (out_right_x == 16'd0) && (out_left_depth == 16'd0) && (out_right_depth == 16'd0), "empty span carries nonzero points")
  `TESI_ASSERT_IMP(a_x_order, out_valid && out_span_valid, out_left_x <= out_right_x, "left x above right x")
  `TESI_ASSERT_IMP(a_stall_full, !in_ready, out_valid && !out_ready, "input stalled without a held result")

endmodule
`default_nettype wire

@@ verif/triangle_scanline_edge_interpolator_top_tb.sv @@
// Testbench for the triangle scanline edge interpolator: directed and random rows per triangle.
`default_nettype none
module triangle_scanline_edge_interpolator_top_tb;
  import tesi_pkg::*;

  typedef struct packed {
    logic        span;
    logic [15:0] lx;
    logic [15:0] ld;
    logic [7:0]  lu;
    logic [7:0]  lv;
    logic [15:0] rx;
    logic [15:0] rd;
    logic [7:0]  ru;
    logic [7:0]  rv;
  } span_pts_t;

  typedef struct {
    longint x, y, d, u, v;
  } pt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_VERTEX_A;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_scan_line = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  span_pts_t   got;

  vertex_t   tri_vtx [3];
  logic [15:0] row_queue [$];
  span_pts_t expected_spans [$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  int        rows_sent = 0;
  int        spans_checked = 0;
  int        valid_spans = 0;
  int        triangles = 0;

  triangle_scanline_edge_interpolator_top dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_scan_line,
    .out_valid, .out_ready,
    .out_span_valid(got.span), .out_left_x(got.lx), .out_left_depth(got.ld),
    .out_left_u(got.lu), .out_left_v(got.lv), .out_right_x(got.rx),
    .out_right_depth(got.rd), .out_right_u(got.ru), .out_right_v(got.rv)
  );

  always #5 clk = ~clk;

  // Floor-rounded interpolation between two endpoint values
  function automatic longint interp(longint s, longint e, longint off, longint dy);
    longint n;
    longint q;
    n = off * (e - s);
    q = n / dy;
    if (n < 0 && q * dy != n) q = q - 1;
    return s + q;
  endfunction

  function automatic pt_t edge_at(pt_t a, pt_t b, longint off);
    pt_t r;
    longint dy;
    dy = b.y - a.y;
    r.x = interp(a.x, b.x, off, dy);
    r.d = interp(a.d, b.d, off, dy);
    r.u = interp(a.u, b.u, off, dy);
    r.v = interp(a.v, b.v, off, dy);
    r.y = 0;
    return r;
  endfunction

  function automatic span_pts_t predict_span(logic [15:0] row);
    pt_t p [3];
    pt_t t, lp, rp;
    longint ln;
    span_pts_t s;
    for (int i = 0; i < 3; i++) begin
      p[i].x = tri_vtx[i].x; p[i].y = tri_vtx[i].y; p[i].d = tri_vtx[i].d;
      p[i].u = tri_vtx[i].u; p[i].v = tri_vtx[i].v;
    end
    if (p[0].y > p[1].y) begin t = p[0]; p[0] = p[1]; p[1] = t; end
    if (p[1].y > p[2].y) begin t = p[1]; p[1] = p[2]; p[2] = t; end
    if (p[0].y > p[1].y) begin t = p[0]; p[0] = p[1]; p[1] = t; end
    s = '0;
    ln = row;
    if (p[0].y == p[2].y || ln < p[0].y || ln > p[2].y) return s;
    lp = edge_at(p[0], p[2], ln - p[0].y);
    // Upper half unless it has zero height
    if (ln <= p[1].y && p[1].y > p[0].y) rp = edge_at(p[0], p[1], ln - p[0].y);
    else rp = edge_at(p[1], p[2], ln - p[1].y);
    if (lp.x > rp.x) begin t = lp; lp = rp; rp = t; end
    s.span = 1'b1;
    s.lx = lp.x[15:0]; s.ld = lp.d[15:0]; s.lu = lp.u[7:0]; s.lv = lp.v[7:0];
    s.rx = rp.x[15:0]; s.rd = rp.d[15:0]; s.ru = rp.u[7:0]; s.rv = rp.v[7:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] g, logic [15:0] e);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, g, e);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (row_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_scan_line <= row_queue[0];
          expected_spans.push_back(predict_span(row_queue[0]));
          void'(row_queue.pop_front());
          rows_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    span_pts_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("unexpected result", 16'd0, 16'd0);
      end else begin
        e = expected_spans.pop_front();
        spans_checked++;
        if (e.span) valid_spans++;
        if (got.span !== e.span) report_mismatch("span_valid", 16'(got.span), 16'(e.span));
        if (got.lx !== e.lx) report_mismatch("left_x", got.lx, e.lx);
        if (got.ld !== e.ld) report_mismatch("left_depth", got.ld, e.ld);
        if (got.lu !== e.lu) report_mismatch("left_u", 16'(got.lu), 16'(e.lu));
        if (got.lv !== e.lv) report_mismatch("left_v", 16'(got.lv), 16'(e.lv));
        if (got.rx !== e.rx) report_mismatch("right_x", got.rx, e.rx);
        if (got.rd !== e.rd) report_mismatch("right_depth", got.rd, e.rd);
        if (got.ru !== e.ru) report_mismatch("right_u", 16'(got.ru), 16'(e.ru));
        if (got.rv !== e.rv) report_mismatch("right_v", 16'(got.rv), 16'(e.rv));
      end
    end
  end

  task automatic wait_drained();
    while (row_queue.size() > 0 || in_valid || expected_spans.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_vertex(logic [1:0] idx, vertex_t v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tri_vtx[idx] = v;
  endtask

  function automatic vertex_t rand_vertex(int mode);
    vertex_t v;
    v = {$urandom, $urandom};
    // Mostly small y ranges so that rows land inside the span
    if (mode == 0) v.y = 16'(100 + $urandom_range(40));
    else if (mode == 1) v.y = $urandom_range(1) ? 16'(65535 - $urandom_range(30))
                                                : 16'($urandom_range(30));
    return v;
  endfunction

  task automatic load_triangle(vertex_t a, vertex_t b, vertex_t c);
    write_vertex(REG_VERTEX_A, a);
    write_vertex(REG_VERTEX_B, b);
    write_vertex(REG_VERTEX_C, c);
    triangles++;
  endtask

  function automatic logic [15:0] rand_row();
    int lo, hi;
    lo = int'(tri_vtx[0].y); hi = lo;
    for (int i = 1; i < 3; i++) begin
      if (int'(tri_vtx[i].y) < lo) lo = int'(tri_vtx[i].y);
      if (int'(tri_vtx[i].y) > hi) hi = int'(tri_vtx[i].y);
    end
    if ($urandom_range(9) == 0) return 16'($urandom);
    lo = (lo > 2) ? lo - 2 : 0;
    hi = (hi < 65533) ? hi + 2 : 65535;
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic run_phase(int idle, int stall, int n);
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if (k % 12 == 0) begin
        wait_drained();
        load_triangle(rand_vertex($urandom_range(3) == 0 ? 2 : $urandom_range(1)),
                      rand_vertex(0), rand_vertex(0));
        // Sometimes force an equal-y pair
        if ($urandom_range(4) == 0) begin
          vertex_t t;
          t = tri_vtx[2]; t.y = tri_vtx[$urandom_range(1)].y;
          write_vertex(REG_VERTEX_C, t);
        end
      end
      row_queue.push_back(rand_row());
    end
    wait_drained();
  endtask

  initial begin
    vertex_t a, b, c;
    logic [15:0] corner_rows [5];
    corner_rows = '{16'd0, 16'd1, 16'h7fff, 16'hfffe, 16'hffff};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset registers: flat triangle at row 0
    row_queue.push_back(16'd0);
    row_queue.push_back(16'hffff);
    wait_drained();
    // Extremes: full-range values, zero-height upper half
    a = '{x: 16'hffff, y: 16'd0, d: 16'hffff, u: 8'hff, v: 8'hff};
    b = '{x: 16'h0000, y: 16'd0, d: 16'h0000, u: 8'h00, v: 8'h00};
    c = '{x: 16'h8000, y: 16'hffff, d: 16'h1234, u: 8'h80, v: 8'h7f};
    load_triangle(a, b, c);
    foreach (corner_rows[i])
      row_queue.push_back(corner_rows[i]);
    wait_drained();
    // Zero-height lower half, reversed register order, rows outside
    a = '{x: 16'd10, y: 16'd50, d: 16'd0, u: 8'd0, v: 8'd255};
    b = '{x: 16'd200, y: 16'd50, d: 16'hffff, u: 8'd255, v: 8'd0};
    c = '{x: 16'd100, y: 16'd10, d: 16'd500, u: 8'd7, v: 8'd9};
    load_triangle(a, b, c);
    for (int r = 8; r <= 52; r += 4) row_queue.push_back(r[15:0]);
    wait_drained();
    // Flat triangle
    a.y = 16'd77; b.y = 16'd77; c.y = 16'd77;
    load_triangle(a, b, c);
    row_queue.push_back(16'd77);
    row_queue.push_back(16'd78);
    wait_drained();
    run_phase(0, 0, 300);
    run_phase(74, 0, 280);
    run_phase(0, 74, 280);
    run_phase(32, 32, 290);
    $display("rows sent %0d, results checked %0d (%0d inside a span), triangles %0d",
             rows_sent, spans_checked, valid_spans, triangles);
    $display("idle mixes: none, sender 74%%, receiver 74%%, both 32%%");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/tesi_pkg.sv
rtl/tesi_sort.sv
rtl/tesi_setup.sv
rtl/tesi_div.sv
rtl/triangle_scanline_edge_interpolator_top.sv
verif/triangle_scanline_edge_interpolator_top_tb.sv
